>>> sv/wep_pkg.sv
// Shared constants, types and helper functions for the wireframe edge projector.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none
package wep_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CW         = 32;
  localparam int TW         = 16;
  localparam int TF         = 14;
  localparam int SCR_W      = 13;
  localparam int VW         = 39;
  localparam int PW         = VW + TW;
  localparam int SW         = PW + 1;
  localparam int MW         = VW + 9;
  localparam int ZW         = VW - 1;
  localparam int RW         = ZW + 1;
  localparam int EW         = CW + SCR_W;
  localparam int NROT       = 3;
  localparam int DIV_STEPS  = CW;
  localparam int OVF_SH     = CW - FRAC_BITS;
  localparam int LAT_VIEW   = 1 + 2 * NROT;
  localparam int LAT_PROJ   = DIV_STEPS + 3;
  localparam int PROJ_SCALE = 300;

  localparam logic signed [VW-1:0] DEPTH_THR = VW'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [EW-1:0] SCR_LO = -(EW'(1) << FRAC_BITS);

  typedef enum logic [2:0] {
    REG_CAM_X,
    REG_CAM_Y,
    REG_CAM_Z,
    REG_YAW,
    REG_PITCH,
    REG_ROLL,
    REG_SCREEN_W,
    REG_SCREEN_H
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] cam_x;
    logic signed [CW-1:0] cam_y;
    logic signed [CW-1:0] cam_z;
    logic [CW-1:0]        yaw_trig;
    logic [CW-1:0]        pitch_trig;
    logic [CW-1:0]        roll_trig;
    logic [SCR_W-1:0]     screen_w;
    logic [SCR_W-1:0]     screen_h;
  } cfg_t;

  typedef struct packed {
    logic neg;
    logic zpos;
    logic nz;
    logic ovf;
  } pflag_t;

  typedef logic signed [VW-1:0] vcoord_t;

  function automatic vcoord_t rot_round(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = (s + SW'(1 << (TF - 1))) >>> TF;
    return t[VW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat32(input logic signed [EW-1:0] v);
    if (v > EW'(SMAX)) begin
      return SMAX;
    end else if (v < EW'(SMIN)) begin
      return SMIN;
    end
    return v[CW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/wep_view_lane.sv
// One endpoint lane: camera translation followed by the yaw, pitch and roll rotations.
// Depends on wep_pkg. All stages are registered and advance only when en is high.
`default_nettype none
module wep_view_lane (
  input  wire                          clk,
  input  wire                          en,
  input  wire wep_pkg::cfg_t           cfg,
  input  wire logic signed [wep_pkg::CW-1:0] px,
  input  wire logic signed [wep_pkg::CW-1:0] py,
  input  wire logic signed [wep_pkg::CW-1:0] pz,
  output wep_pkg::vcoord_t             vx,
  output wep_pkg::vcoord_t             vy,
  output wep_pkg::vcoord_t             vz
);
  import wep_pkg::*;

  wire vcoord_t   vec [NROT+1][3];
  vcoord_t        d_r [3];
  logic [CW-1:0]  trig [NROT];

  assign trig[0] = cfg.yaw_trig;
  assign trig[1] = cfg.pitch_trig;
  assign trig[2] = cfg.roll_trig;

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= VW'(px) - VW'(cfg.cam_x);
      d_r[1] <= VW'(py) - VW'(cfg.cam_y);
      d_r[2] <= VW'(pz) - VW'(cfg.cam_z);
    end
  end

  assign vec[0] = d_r;

  for (genvar k = 0; k < NROT; k++) begin : g_rot
    localparam int A = (k == 1) ? 1 : 0;
    localparam int B = (k == 2) ? 1 : 2;
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
    logic signed [PW-1:0] p_r [4];
    vcoord_t              keep_r [3];
    vcoord_t              res_r [3];

    assign c = trig[k][CW-1:TW];
    assign s = trig[k][TW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[0] <= PW'(vec[k][A]) * PW'(c);
        p_r[1] <= PW'(vec[k][B]) * PW'(s);
        p_r[2] <= PW'(vec[k][A]) * PW'(s);
        p_r[3] <= PW'(vec[k][B]) * PW'(c);
        keep_r <= vec[k];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_ax
      always_ff @(posedge clk) begin
        if (en) begin
          if (j == A) begin
            res_r[j] <= rot_round(SW'(p_r[0]) - SW'(p_r[1]));
          end else if (j == B) begin
            res_r[j] <= rot_round(SW'(p_r[2]) + SW'(p_r[3]));
          end else begin
            res_r[j] <= keep_r[j];
          end
        end
      end
    end

    assign vec[k+1] = res_r;
  end

  assign vx = vec[NROT][0];
  assign vy = vec[NROT][1];
  assign vz = vec[NROT][2];

endmodule
`default_nettype wire

>>> sv/wep_proj_lane.sv
// One coordinate lane: scales by 300 and divides by depth one quotient bit per stage.
// Depends on wep_pkg. Registered scale, setup, divide stages and output; result saturated to 32 bits.
`default_nettype none
module wep_proj_lane (
  input  wire                          clk,
  input  wire                          en,
  input  wire wep_pkg::vcoord_t        num,
  input  wire wep_pkg::vcoord_t        z,
  output logic signed [wep_pkg::CW-1:0] q
);
  import wep_pkg::*;

  logic [VW-1:0]  num_abs;
  logic [MW-1:0]  mag_r;
  logic [ZW-1:0]  zu1_r;
  pflag_t         fl1_r;
  logic [ZW-1:0]  rem0_r;
  logic [CW-1:0]  dq0_r;
  logic [ZW-1:0]  zu0_r;
  pflag_t         fl0_r;
  logic signed [CW-1:0] q_nxt;
  logic signed [CW-1:0] q_r;

  wire logic [ZW-1:0] rem [DIV_STEPS+1];
  wire logic [CW-1:0] dq  [DIV_STEPS+1];
  wire logic [ZW-1:0] zu  [DIV_STEPS+1];
  wire pflag_t        fl  [DIV_STEPS+1];

  assign num_abs = num[VW-1] ? VW'(-num) : num;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r      <= MW'(num_abs) * MW'(PROJ_SCALE);
      zu1_r      <= z[ZW-1:0];
      fl1_r.neg  <= num[VW-1];
      fl1_r.zpos <= (z > 0);
      fl1_r.nz   <= (num != 0);
      fl1_r.ovf  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r     <= ZW'(mag_r >> OVF_SH);
      dq0_r      <= {mag_r[OVF_SH-1:0], {FRAC_BITS{1'b0}}};
      zu0_r      <= zu1_r;
      fl0_r.neg  <= fl1_r.neg;
      fl0_r.zpos <= fl1_r.zpos;
      fl0_r.nz   <= fl1_r.nz;
      fl0_r.ovf  <= fl1_r.ovf || (64'(mag_r) >= (64'(zu1_r) << OVF_SH));
    end
  end

  assign rem[0] = rem0_r;
  assign dq[0]  = dq0_r;
  assign zu[0]  = zu0_r;
  assign fl[0]  = fl0_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [RW-1:0] sh;
    logic          ge;
    logic [ZW-1:0] rem_r;
    logic [CW-1:0] dq_r;
    logic [ZW-1:0] zu_r;
    pflag_t        fl_r;

    assign sh = {rem[i], dq[i][CW-1]};
    assign ge = sh >= {1'b0, zu[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? ZW'(sh - {1'b0, zu[i]}) : sh[ZW-1:0];
        dq_r  <= {dq[i][CW-2:0], ge};
        zu_r  <= zu[i];
        fl_r  <= fl[i];
      end
    end

    assign rem[i+1] = rem_r;
    assign dq[i+1]  = dq_r;
    assign zu[i+1]  = zu_r;
    assign fl[i+1]  = fl_r;
  end

  always_comb begin
    if (!fl[DIV_STEPS].zpos) begin
      if (!fl[DIV_STEPS].nz) begin
        q_nxt = '0;
      end else begin
        q_nxt = fl[DIV_STEPS].neg ? SMIN : SMAX;
      end
    end else if (fl[DIV_STEPS].ovf || dq[DIV_STEPS][CW-1]) begin
      q_nxt = fl[DIV_STEPS].neg ? SMIN : SMAX;
    end else if (fl[DIV_STEPS].neg) begin
      q_nxt = -signed'(dq[DIV_STEPS]);
    end else begin
      q_nxt = signed'(dq[DIV_STEPS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

>>> sv/wireframe_edge_projector.sv
// Top level of the wireframe edge projector: configuration registers, two view lanes,
// four projection lanes and the merge stage. Depends on wep_pkg and both lane modules.
//
// The block takes one edge per clock unless stalled. Each accepted input beat passes
// through the view lanes for translation and the three rotations, then the scaling
// multiply and the 32-step restoring divide in each coordinate lane, then centering,
// saturation and the screen test in the output register. The whole pipeline stalls
// together when the output register holds a beat that is not taken. Edges with both
// endpoints at or below DEPTH_THR in depth, or neither on screen, give no result beat.
// Configuration writes are always ready and must only be issued while the block is idle.
`default_nettype none
module wireframe_edge_projector (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire logic signed [31:0]      in_start_x,
  input  wire logic signed [31:0]      in_start_y,
  input  wire logic signed [31:0]      in_start_z,
  input  wire logic signed [31:0]      in_end_x,
  input  wire logic signed [31:0]      in_end_y,
  input  wire logic signed [31:0]      in_end_z,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [31:0]           out_start_px,
  output logic signed [31:0]           out_start_py,
  output logic signed [31:0]           out_end_px,
  output logic signed [31:0]           out_end_py,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [31:0]             cfg_data
);
  import wep_pkg::*;

  cfg_t                 cfg_r;
  logic                 adv;
  logic [LAT_VIEW-1:0]  vv_r;
  logic [LAT_PROJ-1:0]  pv_r;
  vcoord_t              sx, sy, sz, ex, ey, ez;
  logic signed [CW-1:0] qsx, qsy, qex, qey;
  logic signed [EW-1:0] cw_s, ch_s, wf_s, hf_s;
  logic signed [CW-1:0] spx, spy, epx, epy;
  logic                 on_s, on_e;
  logic                 out_valid_r;
  logic signed [CW-1:0] spx_r, spy_r, epx_r, epy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x      <= '0;
      cfg_r.cam_y      <= '0;
      cfg_r.cam_z      <= '0;
      cfg_r.yaw_trig   <= 32'h4000_0000;
      cfg_r.pitch_trig <= 32'h4000_0000;
      cfg_r.roll_trig  <= 32'h4000_0000;
      cfg_r.screen_w   <= SCR_W'(800);
      cfg_r.screen_h   <= SCR_W'(600);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAM_X:    cfg_r.cam_x      <= signed'(cfg_data);
        REG_CAM_Y:    cfg_r.cam_y      <= signed'(cfg_data);
        REG_CAM_Z:    cfg_r.cam_z      <= signed'(cfg_data);
        REG_YAW:      cfg_r.yaw_trig   <= cfg_data;
        REG_PITCH:    cfg_r.pitch_trig <= cfg_data;
        REG_ROLL:     cfg_r.roll_trig  <= cfg_data;
        REG_SCREEN_W: cfg_r.screen_w   <= cfg_data[SCR_W-1:0];
        REG_SCREEN_H: cfg_r.screen_h   <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r        <= '0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vv_r        <= {vv_r[LAT_VIEW-2:0], in_valid};
      pv_r        <= {pv_r[LAT_PROJ-2:0],
                      vv_r[LAT_VIEW-1] && !(sz <= DEPTH_THR && ez <= DEPTH_THR)};
      out_valid_r <= pv_r[LAT_PROJ-1] && (on_s || on_e);
    end
  end

  wep_view_lane u_view_s (
    .clk (clk), .en (adv), .cfg (cfg_r),
    .px (in_start_x), .py (in_start_y), .pz (in_start_z),
    .vx (sx), .vy (sy), .vz (sz)
  );

  wep_view_lane u_view_e (
    .clk (clk), .en (adv), .cfg (cfg_r),
    .px (in_end_x), .py (in_end_y), .pz (in_end_z),
    .vx (ex), .vy (ey), .vz (ez)
  );

  wep_proj_lane u_proj_sx (.clk (clk), .en (adv), .num (sx), .z (sz), .q (qsx));
  wep_proj_lane u_proj_sy (.clk (clk), .en (adv), .num (sy), .z (sz), .q (qsy));
  wep_proj_lane u_proj_ex (.clk (clk), .en (adv), .num (ex), .z (ez), .q (qex));
  wep_proj_lane u_proj_ey (.clk (clk), .en (adv), .num (ey), .z (ez), .q (qey));

  assign cw_s = signed'(EW'({cfg_r.screen_w, {(FRAC_BITS-1){1'b0}}}));
  assign ch_s = signed'(EW'({cfg_r.screen_h, {(FRAC_BITS-1){1'b0}}}));
  assign wf_s = signed'(EW'({cfg_r.screen_w, {FRAC_BITS{1'b0}}}));
  assign hf_s = signed'(EW'({cfg_r.screen_h, {FRAC_BITS{1'b0}}}));

  assign spx = sat32(cw_s + EW'(qsx));
  assign spy = sat32(ch_s - EW'(qsy));
  assign epx = sat32(cw_s + EW'(qex));
  assign epy = sat32(ch_s - EW'(qey));

  assign on_s = (EW'(spx) >= SCR_LO) && (EW'(spx) <= wf_s) &&
                (EW'(spy) >= SCR_LO) && (EW'(spy) <= hf_s);
  assign on_e = (EW'(epx) >= SCR_LO) && (EW'(epx) <= wf_s) &&
                (EW'(epy) >= SCR_LO) && (EW'(epy) <= hf_s);

  always_ff @(posedge clk) begin
    if (adv) begin
      spx_r <= spx;
      spy_r <= spy;
      epx_r <= epx;
      epy_r <= epy;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_start_px = spx_r;
  assign out_start_py = spy_r;
  assign out_end_px   = epx_r;
  assign out_end_py   = epy_r;

endmodule
`default_nettype wire
